/* rtl/ctcgd_pkg.sv */
// Shared types and constants for the greedy CTC decoder.
package ctcgd_pkg;

   localparam int ScoreW     = 16;
   localparam int IndexW     = 13;
   localparam int CountW     = 9;
   localparam int SumW       = 24;
   localparam int IndexSpan  = 2 ** IndexW;
   localparam int CountSpan  = 256;
   localparam int QueueDepth = 4;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [ScoreW-1:0] class_score;
      logic              step_end;
      logic              sequence_end;
   } req_type;

   typedef struct packed {
      logic              kind_out;
      logic [IndexW-1:0] label_index;
      logic [ScoreW-1:0] char_score;
      logic [CountW-1:0] char_count;
      logic              empty_text;
      logic              last_result;
   } rsp_type;

   // Work handed from the front end to the back end for one input transaction.
   typedef struct packed {
      logic              has_char;
      logic [IndexW-1:0] label;
      logic [ScoreW-1:0] score;
      logic              has_summary;
      logic [SumW-1:0]   score_sum;
      logic [CountW-1:0] count;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

/* rtl/ctcgd_front.sv */
// Front end: running max over a step, repeat/blank filter, sequence totals.
module ctcgd_front
   import ctcgd_pkg::*;
#(
   parameter int MAX_CLASSES = 8192,
   parameter int MAX_STEPS   = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_job
);

   localparam int ClassLimit = (MAX_CLASSES < IndexSpan) ? MAX_CLASSES : IndexSpan;
   localparam int CntW       = $clog2(ClassLimit + 1);
   localparam int CountLimit = (MAX_STEPS < CountSpan) ? MAX_STEPS : CountSpan;

   logic [ScoreW-1:0] best_score_ff, best_score_in;
   logic [IndexW-1:0] best_index_ff, best_index_in;
   logic [CntW-1:0]   class_counter_ff, class_counter_in;
   logic [IndexW-1:0] previous_winner_ff, previous_winner_in;
   logic [SumW-1:0]   score_sum_ff, score_sum_in;
   logic [CountW-1:0] emitted_count_ff, emitted_count_in;

   logic              accept;
   logic              in_range;
   logic              take;
   logic [ScoreW-1:0] cur_score;
   logic [IndexW-1:0] cur_index;
   logic              ends;
   logic              emit_char;
   logic              add;
   logic [SumW-1:0]   sum_next;
   logic [CountW-1:0] count_next;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_range   = class_counter_ff < CntW'(ClassLimit);
      take       = in_range && ((class_counter_ff == '0) ||
                                (req_data.class_score > best_score_ff));
      cur_score  = take ? req_data.class_score : best_score_ff;
      cur_index  = take ? IndexW'(class_counter_ff) : best_index_ff;
      ends       = req_data.step_end || req_data.sequence_end;
      emit_char  = ends && (cur_index != '0) && (cur_index != previous_winner_ff);
      // character still emitted past the count limit, just not accumulated
      add        = emit_char && (emitted_count_ff < CountW'(CountLimit));
      sum_next   = add ? score_sum_ff + SumW'(cur_score) : score_sum_ff;
      count_next = add ? emitted_count_ff + 1'b1 : emitted_count_ff;

      best_score_in      = best_score_ff;
      best_index_in      = best_index_ff;
      class_counter_in   = class_counter_ff;
      previous_winner_in = previous_winner_ff;
      score_sum_in       = score_sum_ff;
      emitted_count_in   = emitted_count_ff;

      if (accept) begin
         score_sum_in     = sum_next;
         emitted_count_in = count_next;
         if (ends) begin
            best_score_in      = '0;
            best_index_in      = '0;
            class_counter_in   = '0;
            previous_winner_in = cur_index;
         end else begin
            best_score_in    = cur_score;
            best_index_in    = cur_index;
            class_counter_in = in_range ? CntW'(class_counter_ff + 1'b1) : class_counter_ff;
         end
         if (req_data.sequence_end) begin
            previous_winner_in = '0;
            score_sum_in       = '0;
            emitted_count_in   = '0;
         end
      end

      q_push            = accept && (emit_char || req_data.sequence_end);
      q_job.has_char    = emit_char;
      q_job.label       = cur_index;
      q_job.score       = cur_score;
      q_job.has_summary = req_data.sequence_end;
      q_job.score_sum   = sum_next;
      q_job.count       = count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff      <= '0;
         best_index_ff      <= '0;
         class_counter_ff   <= '0;
         previous_winner_ff <= '0;
         score_sum_ff       <= '0;
         emitted_count_ff   <= '0;
      end else begin
         best_score_ff      <= best_score_in;
         best_index_ff      <= best_index_in;
         class_counter_ff   <= class_counter_in;
         previous_winner_ff <= previous_winner_in;
         score_sum_ff       <= score_sum_in;
         emitted_count_ff   <= emitted_count_in;
      end
   end

endmodule

/* rtl/ctcgd_queue.sv */
// Small FIFO of jobs between the front end and the back end.
module ctcgd_queue
   import ctcgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PtrW = $clog2(QueueDepth);

   job_type           entry_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
      status.full      = fill_ff == (PtrW+1)'(QueueDepth);
      status.not_empty = fill_ff != '0;
      head_job         = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/ctcgd_back.sv */
// Back end: emits character results and computes the sequence average.
module ctcgd_back
   import ctcgd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam int StepW = $clog2(ScoreW);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SUM,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic [CountW-1:0] rem_ff;
   logic [ScoreW-1:0] dq_ff;
   logic [StepW-1:0]  step_ff;

   logic              slot_free;
   logic              rsp_load;
   logic [CountW:0]   rem_shift;
   logic              qbit;
   logic [CountW-1:0] rem_in;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      // output register takes a new transaction this cycle
      rsp_load  = slot_free &&
                  (((state_ff == ST_LOAD) && q_status.not_empty && head_job.has_char) ||
                   ((state_ff == ST_SUM) && (head_job.count == '0)) ||
                   (state_ff == ST_EMIT));
      // one quotient bit per cycle; the high sum bits are already below count
      rem_shift = {rem_ff, dq_ff[ScoreW-1]};
      qbit      = rem_shift >= {1'b0, head_job.count};
      rem_in    = qbit ? CountW'(rem_shift - {1'b0, head_job.count})
                       : CountW'(rem_shift);
      q_pop = 1'b0;
      unique case (state_ff)
         ST_LOAD: q_pop = q_status.not_empty && head_job.has_char &&
                          !head_job.has_summary && slot_free;
         ST_SUM:  q_pop = (head_job.count == '0) && slot_free;
         ST_DIV:  q_pop = 1'b0;
         ST_EMIT: q_pop = slot_free;
         default: q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
         rem_ff       <= '0;
         dq_ff        <= '0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_LOAD: begin
               if (q_status.not_empty) begin
                  if (!head_job.has_char) begin
                     state_ff <= ST_SUM;
                  end else if (slot_free) begin
                     rsp_data_ff.kind_out    <= KIND_CHAR;
                     rsp_data_ff.label_index <= head_job.label;
                     rsp_data_ff.char_score  <= head_job.score;
                     rsp_data_ff.char_count  <= '0;
                     rsp_data_ff.empty_text  <= 1'b0;
                     rsp_data_ff.last_result <= !head_job.has_summary;
                     if (head_job.has_summary) begin
                        state_ff <= ST_SUM;
                     end
                  end
               end
            end
            ST_SUM: begin
               if (head_job.count == '0) begin
                  if (slot_free) begin
                     rsp_data_ff.kind_out    <= KIND_SUMMARY;
                     rsp_data_ff.label_index <= '0;
                     rsp_data_ff.char_score  <= '0;
                     rsp_data_ff.char_count  <= '0;
                     rsp_data_ff.empty_text  <= 1'b1;
                     rsp_data_ff.last_result <= 1'b1;
                     state_ff                <= ST_LOAD;
                  end
               end else begin
                  rem_ff   <= CountW'(head_job.score_sum[SumW-1:ScoreW]);
                  dq_ff    <= head_job.score_sum[ScoreW-1:0];
                  step_ff  <= StepW'(ScoreW - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_in;
               dq_ff   <= {dq_ff[ScoreW-2:0], qbit};
               step_ff <= step_ff - 1'b1;
               if (step_ff == '0) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_data_ff.kind_out    <= KIND_SUMMARY;
                  rsp_data_ff.label_index <= '0;
                  rsp_data_ff.char_score  <= dq_ff;
                  rsp_data_ff.char_count  <= head_job.count;
                  rsp_data_ff.empty_text  <= 1'b0;
                  rsp_data_ff.last_result <= 1'b1;
                  state_ff                <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

/* rtl/ctc_greedy_decoder.sv */
// Greedy CTC decoder top level: front end, job queue and back end.
// The decoder accepts one class score per cycle whenever its four-entry job
// queue has room; the front end resolves each time step's winner on the fly.
// A character result is loaded into the output register once its job is at
// the queue head and the output slot is free. A sequence summary goes through
// a queue head check, setup, a 16-step bit-serial restoring divider for
// floor(sum / count), and the output load; an empty sequence is loaded in
// setup. The summary job keeps its queue entry while the divider runs, so
// the input stalls only if three more jobs (character steps or sequence
// ends) arrive meanwhile, or when the result side holds off.
module ctc_greedy_decoder
   import ctcgd_pkg::*;
#(
   parameter int MAX_CLASSES = 8192,
   parameter int MAX_STEPS   = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          q_push_job;
   job_type          q_head_job;

   ctcgd_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_STEPS   (MAX_STEPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (q_push_job)
   );

   ctcgd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .status   (q_status)
   );

   ctcgd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (q_head_job),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.not_empty)
      else $error("job queue read while empty");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind_out == KIND_SUMMARY) |->
         rsp_data.last_result && (rsp_data.label_index == '0))
      else $error("summary transaction not last or has a label");

   a_char_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind_out == KIND_CHAR) |->
         (rsp_data.label_index != '0) && !rsp_data.empty_text)
      else $error("character transaction with blank label");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_text |->
         (rsp_data.char_count == '0) && (rsp_data.char_score == '0))
      else $error("empty summary carries a count or score");

endmodule
